// ===== src/cscan_pkg.sv =====
`default_nettype none

package cscan_pkg;

  // track numbers are carried at the full field width
  localparam int unsigned TRACK_BITS = 16;
  localparam int unsigned PEND_BITS  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRACKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK = 2'd2;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  // sweep direction codes
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_SERVED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic                  cmd;
    logic [TRACK_BITS-1:0] track;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [TRACK_BITS-1:0] served_track;
    logic [TRACK_BITS-1:0] seek_distance;
    logic [31:0]           total_seek;
    logic [31:0]           served_total;
    logic [PEND_BITS-1:0]  pending;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/cscan_ram.sv =====
`default_nettype none

module cscan_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/cscan_disk_request_scheduler.sv =====
// C-SCAN disk request scheduler.
// Input channel (in_valid / in_stall / in_data): each transaction is an add
// (append a track to the request store) or a serve (choose, remove and report
// the next track). Every input transaction gives exactly one result on the
// output channel (out_valid / out_stall / out_data).
// Steps: an add, or a serve on an empty store, goes from idle to the done state
// and then into the output register. A serve scans the N entries of the current
// batch (one store entry read and compared per cycle through the single read
// port), then moves K entries down to close the gap (one per cycle), then
// updates the head and totals before the done state. One transaction is in
// work at a time; in_stall is high from accept until its result is loaded
// into the output register.
// The output register holds one finished result; a new input transaction may
// be accepted while it waits. When the receiver stalls, the result holds and
// a finished item waits in its last step until the register frees up.
// Reset (rst_n low, synchronous) empties the store, clears the totals, the
// batch and the head, and sets the sweep direction to increasing tracks.
// Configuration writes (cfg_we, cfg_index, cfg_data) are to be made only while idle.
`default_nettype none

module cscan_disk_request_scheduler #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire cscan_pkg::req_t                     in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output cscan_pkg::rsp_t                          out_data,
  input  wire logic                                cfg_we,
  input  wire logic [cscan_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cscan_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned TW    = cscan_pkg::TRACK_BITS;
  localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_MOVE   = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  // control state
  state_t           state_r, state_nxt;
  logic             dir_r;
  logic [TW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] batch_r, batch_nxt;
  logic [31:0]      total_r, total_nxt;
  logic [31:0]      count_r, count_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // scan candidates and payload
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             eq_hit_r, eq_hit_nxt;
  logic [IDX_W-1:0] eq_idx_r, eq_idx_nxt;
  logic             fwd_hit_r, fwd_hit_nxt;
  logic [IDX_W-1:0] fwd_idx_r, fwd_idx_nxt;
  logic [TW-1:0]    fwd_dist_r, fwd_dist_nxt;
  logic [TW-1:0]    fwd_trk_r, fwd_trk_nxt;
  logic             wrp_hit_r, wrp_hit_nxt;
  logic [IDX_W-1:0] wrp_idx_r, wrp_idx_nxt;
  logic [TW-1:0]    wrp_trk_r, wrp_trk_nxt;
  logic [IDX_W-1:0] sel_idx_r, sel_idx_nxt;
  logic [TW-1:0]    sel_trk_r, sel_trk_nxt;
  cscan_pkg::status_t res_status_r, res_status_nxt;
  logic [TW-1:0]    res_trk_r, res_trk_nxt;
  logic [TW-1:0]    res_seek_r, res_seek_nxt;
  cscan_pkg::rsp_t  out_data_r, out_data_nxt;

  // memory port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [TW-1:0]    ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [TW-1:0]    ram_rdata;

  // shared distance unit
  logic [TW-1:0] abs_a;
  logic          abs_gt;
  logic [TW-1:0] abs_big, abs_small, abs_d;

  logic          in_acc;
  logic          out_free;
  logic          is_eq, ahead, wrap_better;
  logic [32:0]   sum_w;

  cscan_ram #(
    .WIDTH (TW),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // absolute distance from the head: scanned entry, or the chosen track later
  assign abs_a     = (state_r == S_SCAN) ? ram_rdata : sel_trk_r;
  assign abs_gt    = abs_a > head_r;
  assign abs_big   = abs_gt ? abs_a : head_r;
  assign abs_small = abs_gt ? head_r : abs_a;
  assign abs_d     = abs_big - abs_small;

  // classification of the entry being scanned
  assign is_eq       = (ram_rdata == head_r);
  assign ahead       = (dir_r == cscan_pkg::DIR_DOWN) ? (ram_rdata < head_r) : abs_gt;
  assign wrap_better = (dir_r == cscan_pkg::DIR_DOWN) ? (ram_rdata > wrp_trk_r)
                                                     : (ram_rdata < wrp_trk_r);

  // saturating seek total
  assign sum_w = {1'b0, total_r} + 33'(abs_d);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    batch_nxt      = batch_r;
    total_nxt      = total_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = iss_r[IDX_W-1:0];
    out_valid_nxt  = out_valid_r && out_stall;
    eq_hit_nxt     = eq_hit_r;
    eq_idx_nxt     = eq_idx_r;
    fwd_hit_nxt    = fwd_hit_r;
    fwd_idx_nxt    = fwd_idx_r;
    fwd_dist_nxt   = fwd_dist_r;
    fwd_trk_nxt    = fwd_trk_r;
    wrp_hit_nxt    = wrp_hit_r;
    wrp_idx_nxt    = wrp_idx_r;
    wrp_trk_nxt    = wrp_trk_r;
    sel_idx_nxt    = sel_idx_r;
    sel_trk_nxt    = sel_trk_r;
    res_status_nxt = res_status_r;
    res_trk_nxt    = res_trk_r;
    res_seek_nxt   = res_seek_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = fill_r[IDX_W-1:0];
    ram_wdata      = in_data.track;
    ram_raddr      = iss_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_trk_nxt  = '0;
          res_seek_nxt = '0;
          if (in_data.cmd == cscan_pkg::CMD_ADD) begin
            if (fill_r >= DEPTH_C) begin
              res_status_nxt = cscan_pkg::ST_FULL;
            end else begin
              ram_we         = 1'b1;
              fill_nxt       = fill_r + 1'b1;
              res_status_nxt = cscan_pkg::ST_ADDED;
            end
            state_nxt = S_DONE;
          end else if (fill_r == '0) begin
            res_status_nxt = cscan_pkg::ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            // a spent batch takes in every entry held now
            if (batch_r == '0 || batch_r > fill_r) begin
              batch_nxt = fill_r;
            end
            iss_nxt     = '0;
            eq_hit_nxt  = 1'b0;
            fwd_hit_nxt = 1'b0;
            wrp_hit_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle over the batch
        if (iss_r < batch_r) begin
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (is_eq) begin
            if (!eq_hit_r) begin
              eq_hit_nxt = 1'b1;
              eq_idx_nxt = rd_idx_r;
            end
          end else if (ahead) begin
            if (!fwd_hit_r || abs_d < fwd_dist_r) begin
              fwd_hit_nxt  = 1'b1;
              fwd_idx_nxt  = rd_idx_r;
              fwd_dist_nxt = abs_d;
              fwd_trk_nxt  = ram_rdata;
            end
          end else begin
            if (!wrp_hit_r || wrap_better) begin
              wrp_hit_nxt = 1'b1;
              wrp_idx_nxt = rd_idx_r;
              wrp_trk_nxt = ram_rdata;
            end
          end
          // last batch entry compared: settle the choice
          if (CNT_W'(rd_idx_r) == batch_r - 1'b1) begin
            if (eq_hit_nxt) begin
              sel_idx_nxt = eq_idx_nxt;
              sel_trk_nxt = head_r;
            end else if (fwd_hit_nxt) begin
              sel_idx_nxt = fwd_idx_nxt;
              sel_trk_nxt = fwd_trk_nxt;
            end else begin
              sel_idx_nxt = wrp_idx_nxt;
              sel_trk_nxt = wrp_trk_nxt;
            end
            rd_vld_nxt = 1'b0;
            iss_nxt    = CNT_W'(sel_idx_nxt) + 1'b1;
            state_nxt  = S_MOVE;
          end
        end
      end

      S_MOVE: begin
        // shift entries above the chosen one down by one place
        if (iss_r < fill_r) begin
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r + 1'b1;
        end
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (iss_r >= fill_r && !rd_vld_r) begin
          state_nxt = S_UPDATE;
        end
      end

      S_UPDATE: begin
        res_status_nxt = cscan_pkg::ST_SERVED;
        res_trk_nxt    = sel_trk_r;
        res_seek_nxt   = abs_d;
        total_nxt      = sum_w[32] ? '1 : sum_w[31:0];
        if (count_r != '1) begin
          count_nxt = count_r + 1'b1;
        end
        fill_nxt  = fill_r - 1'b1;
        batch_nxt = batch_r - 1'b1;
        head_nxt  = sel_trk_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = res_status_r;
          out_data_nxt.served_track  = res_trk_r;
          out_data_nxt.seek_distance = res_seek_r;
          out_data_nxt.total_seek    = total_r;
          out_data_nxt.served_total  = count_r;
          out_data_nxt.pending       = cscan_pkg::PEND_BITS'(fill_r);
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // start position loads the head until the first serve
    if (cfg_we && cfg_index == cscan_pkg::CFG_START_TRACK && count_r == '0) begin
      head_nxt = cfg_data[TW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= cscan_pkg::DIR_UP;
      head_r      <= '0;
      fill_r      <= '0;
      batch_r     <= '0;
      total_r     <= '0;
      count_r     <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      batch_r     <= batch_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      // disk size is held outside; it does not change any choice or distance
      if (cfg_we && cfg_index == cscan_pkg::CFG_DIRECTION) begin
        dir_r <= cfg_data[0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    eq_hit_r     <= eq_hit_nxt;
    eq_idx_r     <= eq_idx_nxt;
    fwd_hit_r    <= fwd_hit_nxt;
    fwd_idx_r    <= fwd_idx_nxt;
    fwd_dist_r   <= fwd_dist_nxt;
    fwd_trk_r    <= fwd_trk_nxt;
    wrp_hit_r    <= wrp_hit_nxt;
    wrp_idx_r    <= wrp_idx_nxt;
    wrp_trk_r    <= wrp_trk_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_trk_r    <= sel_trk_nxt;
    res_status_r <= res_status_nxt;
    res_trk_r    <= res_trk_nxt;
    res_seek_r   <= res_seek_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire
